FILE: hdl/spmq_pkg.sv
`default_nettype none
package spmq_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF   = 16;
    localparam int unsigned PAYLOAD_BYTES_DEF = 8;
    localparam int unsigned PRIORITY_BITS_DEF = 16;

    localparam logic [4:0] MAX_MESSAGES_RST = 5'd8;
    localparam logic [3:0] MESSAGE_SIZE_RST = 4'd8;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TOO_BIG = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } spmq_status_t;

    typedef enum logic {
        FUNC_SEND = 1'b0,
        FUNC_RECV = 1'b1
    } spmq_func_t;

    localparam logic CFG_MAX_MESSAGES = 1'b0;
    localparam logic CFG_MESSAGE_SIZE = 1'b1;

    typedef struct packed {
        logic [0:0]  func;
        logic [7:0]  length;
        logic [15:0] priority_req;
        logic [63:0] payload;
    } spmq_in_t;

    typedef struct packed {
        spmq_status_t status;
        logic [63:0]  out_payload;
        logic [3:0]   out_length;
        logic [15:0]  out_priority;
        logic [4:0]   message_count;
    } spmq_out_t;

    typedef struct packed {
        logic push;
        logic pop;
    } spmq_cmd_t;

endpackage
`default_nettype wire

FILE: hdl/spmq_cell.sv
`default_nettype none
module spmq_cell #(
    parameter int unsigned QUEUE_DEPTH   = 16,
    parameter int unsigned PAYLOAD_BYTES = 8,
    parameter int unsigned PRIORITY_BITS = 16,
    parameter int unsigned INDEX         = 0
) (
    input  wire                                  aclk,
    input  spmq_pkg::spmq_cmd_t                  cmd,
    input  wire  [$clog2(QUEUE_DEPTH+1)-1:0]     count,
    input  wire  [PRIORITY_BITS-1:0]             new_prio,
    input  wire  [3:0]                           new_len,
    input  wire  [PAYLOAD_BYTES*8-1:0]           new_data,
    input  wire                                  left_keep,
    input  wire  [PRIORITY_BITS-1:0]             left_prio,
    input  wire  [3:0]                           left_len,
    input  wire  [PAYLOAD_BYTES*8-1:0]           left_data,
    input  wire  [PRIORITY_BITS-1:0]             right_prio,
    input  wire  [3:0]                           right_len,
    input  wire  [PAYLOAD_BYTES*8-1:0]           right_data,
    output logic                                 keep,
    output logic [PRIORITY_BITS-1:0]             prio,
    output logic [3:0]                           len,
    output logic [PAYLOAD_BYTES*8-1:0]           data
);
    import spmq_pkg::*;

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    logic [PRIORITY_BITS-1:0]   prio_reg, prio_next;
    logic [3:0]                 len_reg, len_next;
    logic [PAYLOAD_BYTES*8-1:0] data_reg, data_next;
    logic                       occupied;

    assign occupied = CW'(INDEX) < count;
    assign keep     = occupied && (prio_reg >= new_prio);

    always_comb begin
        prio_next = prio_reg;
        len_next  = len_reg;
        data_next = data_reg;
        if (cmd.push && !keep) begin
            if (left_keep) begin
                prio_next = new_prio;
                len_next  = new_len;
                data_next = new_data;
            end else begin
                prio_next = left_prio;
                len_next  = left_len;
                data_next = left_data;
            end
        end else if (cmd.pop) begin
            prio_next = right_prio;
            len_next  = right_len;
            data_next = right_data;
        end
    end

    always_ff @(posedge aclk) begin
        prio_reg <= prio_next;
        len_reg  <= len_next;
        data_reg <= data_next;
    end

    assign prio = prio_reg;
    assign len  = len_reg;
    assign data = data_reg;

endmodule
`default_nettype wire

FILE: hdl/stable_priority_message_queue_unit.sv
// Stable priority message queue.
// Input channel s_valid/s_ready/s_data carries one transaction per request:
// func send or receive, length, priority and a one-word payload.
// Result channel m_valid/m_ready/m_data returns exactly one transaction per
// request: status, received payload/length/priority and the message count.
// Messages sit in a row of cells, ordered by descending priority and in
// arrival order within a priority; every cell updates in the same cycle, so
// a send inserts and a receive pops the head with one update of all cells.
// The result is registered and valid in the cycle after the request is accepted.
// Throughput: one transaction per cycle, limited only by the result register.
// When m_ready is low, the held result stays and s_ready drops until it
// is taken; nothing is lost.
// Reset (aresetn low, synchronous) empties the queue, drops m_valid
// and loads max_messages = 8, message_size = 8.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr
// (0 max_messages, 1 message_size); write only while the block is idle.
`default_nettype none
module stable_priority_message_queue_unit #(
    parameter int unsigned QUEUE_DEPTH   = spmq_pkg::QUEUE_DEPTH_DEF,
    parameter int unsigned PAYLOAD_BYTES = spmq_pkg::PAYLOAD_BYTES_DEF,
    parameter int unsigned PRIORITY_BITS = spmq_pkg::PRIORITY_BITS_DEF
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  cfg_we,
    input  wire                  cfg_addr,
    input  wire  [4:0]           cfg_wdata,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  spmq_pkg::spmq_in_t   s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output spmq_pkg::spmq_out_t  m_data
);
    import spmq_pkg::*;

    localparam int unsigned CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned CMPW = (CW > 5) ? CW : 5;
    localparam int unsigned DW   = PAYLOAD_BYTES * 8;

    logic [4:0]    max_messages_reg;
    logic [3:0]    message_size_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          out_valid_reg;
    spmq_out_t     out_reg, out_next;

    logic            accept;
    spmq_cmd_t       cmd;
    logic [3:0]      size_eff;
    logic [CMPW-1:0] mm_ext, cap, cnt_ext, cnt_next_ext;
    logic [31:0]     prio_ext;
    logic [PRIORITY_BITS-1:0] new_prio;
    logic [DW-1:0]   new_data;
    logic [31:0]     head_prio_ext;

    logic                     keep_w [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] prio_w [QUEUE_DEPTH];
    logic [3:0]               len_w  [QUEUE_DEPTH];
    logic [DW-1:0]            data_w [QUEUE_DEPTH];

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign size_eff = (message_size_reg < 4'(PAYLOAD_BYTES)) ? message_size_reg
                                                             : 4'(PAYLOAD_BYTES);
    assign mm_ext  = CMPW'(max_messages_reg);
    assign cap     = (mm_ext < CMPW'(QUEUE_DEPTH)) ? mm_ext : CMPW'(QUEUE_DEPTH);
    assign cnt_ext = CMPW'(count_reg);

    assign prio_ext = {16'b0, s_data.priority_req};
    assign new_prio = prio_ext[PRIORITY_BITS-1:0];

    always_comb begin
        for (int b = 0; b < PAYLOAD_BYTES; b++) begin
            new_data[b*8 +: 8] = (8'(b) < s_data.length) ? s_data.payload[b*8 +: 8] : 8'h00;
        end
    end

    assign head_prio_ext = 32'(prio_w[0]);

    always_comb begin
        cmd          = '0;
        count_next   = count_reg;
        out_next     = '0;
        if (s_data.func == FUNC_SEND) begin
            if (s_data.length > {4'b0, size_eff}) begin
                out_next.status = ST_TOO_BIG;
            end else if (cnt_ext >= cap) begin
                out_next.status = ST_FULL;
            end else begin
                out_next.status = ST_OK;
                cmd.push        = accept;
                count_next      = count_reg + CW'(1);
            end
        end else begin
            if (s_data.length < {4'b0, size_eff}) begin
                out_next.status = ST_TOO_BIG;
            end else if (count_reg == '0) begin
                out_next.status = ST_EMPTY;
            end else begin
                out_next.status       = ST_OK;
                out_next.out_payload  = 64'(data_w[0]);
                out_next.out_length   = len_w[0];
                out_next.out_priority = head_prio_ext[15:0];
                cmd.pop               = accept;
                count_next            = count_reg - CW'(1);
            end
        end
        cnt_next_ext           = CMPW'(count_next);
        out_next.message_count = cnt_next_ext[4:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_messages_reg <= MAX_MESSAGES_RST;
            message_size_reg <= MESSAGE_SIZE_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_MAX_MESSAGES: max_messages_reg <= cfg_wdata;
                CFG_MESSAGE_SIZE: message_size_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        logic                     lk;
        logic [PRIORITY_BITS-1:0] lp, rp;
        logic [3:0]               ll, rl;
        logic [DW-1:0]            ld, rd;

        if (k == 0) begin : g_first
            assign lk = 1'b1;
            assign lp = new_prio;
            assign ll = s_data.length[3:0];
            assign ld = new_data;
        end else begin : g_mid
            assign lk = keep_w[k-1];
            assign lp = prio_w[k-1];
            assign ll = len_w[k-1];
            assign ld = data_w[k-1];
        end

        if (k == QUEUE_DEPTH - 1) begin : g_last
            assign rp = prio_w[k];
            assign rl = len_w[k];
            assign rd = data_w[k];
        end else begin : g_inner
            assign rp = prio_w[k+1];
            assign rl = len_w[k+1];
            assign rd = data_w[k+1];
        end

        spmq_cell #(
            .QUEUE_DEPTH   (QUEUE_DEPTH),
            .PAYLOAD_BYTES (PAYLOAD_BYTES),
            .PRIORITY_BITS (PRIORITY_BITS),
            .INDEX         (k)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .count      (count_reg),
            .new_prio   (new_prio),
            .new_len    (s_data.length[3:0]),
            .new_data   (new_data),
            .left_keep  (lk),
            .left_prio  (lp),
            .left_len   (ll),
            .left_data  (ld),
            .right_prio (rp),
            .right_len  (rl),
            .right_data (rd),
            .keep       (keep_w[k]),
            .prio       (prio_w[k]),
            .len        (len_w[k]),
            .data       (data_w[k])
        );
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMPW'(count_reg) <= CMPW'(QUEUE_DEPTH))
        else $error("message count above queue depth");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not bump the count");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_EMPTY) |-> m_data.message_count == 5'd0)
        else $error("empty status with messages held");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> $stable(count_reg))
        else $error("queue changed while the result was stalled");

endmodule
`default_nettype wire
